/* src/hcc_pkg.sv */
package hcc_pkg;

    // Width of the bit count, the code length and the error position.
    localparam int CNT_W = 7;

    typedef logic [CNT_W-1:0] cnt_t;

    // Control of the syndrome accumulator by the sequencer.
    typedef struct packed {
        logic clear;
        logic en;
        logic bit_val;
        cnt_t pos;
    } syn_ctl_t;

    // All power-of-two positions that do not lie beyond the code length.
    function automatic cnt_t group_mask(input cnt_t len);
        cnt_t m;
        m = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            m[b] = ((CNT_W + 1)'(1) << b) <= {1'b0, len};
        end
        return m;
    endfunction

endpackage

/* src/hamming_code_check_correct.sv */
// Serial Hamming single-error-correcting decoder.
// During loading a code bit is accepted in every cycle in which one is offered.
// After the final bit the stored word of length L is read once through the single read
// port of the bit memory to form the syndrome, then read again and sent out at one
// result per cycle while result_stall is low.
// Reset clears the control state and odd_parity; the bit memory itself is not cleared.
module hamming_code_check_correct #(
    parameter int MAX_CODE_BITS = 64
) (
    input  logic clk,
    input  logic rst_n,

    // Configuration: odd_parity, written while the block is idle.
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data,

    // Input code bits.
    input  logic code_valid,
    output logic code_stall,
    input  logic code_bit,
    input  logic final_bit,

    // Corrected results.
    output logic result_valid,
    input  logic result_stall,
    output logic corrected_bit,
    output logic [6:0] error_position,
    output logic position_invalid,
    output logic overflowed,
    output logic run_end
);

    import hcc_pkg::*;

    localparam int   AW      = (MAX_CODE_BITS > 2) ? $clog2(MAX_CODE_BITS) : 1;
    localparam cnt_t MAX_CNT = CNT_W'(MAX_CODE_BITS);

    // The sequencer loads bits, scans them for the syndrome and then emits them.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t   state_reg, state_next;
    cnt_t     count_reg, count_next;
    logic     ovf_reg, ovf_next;
    cnt_t     len_reg, len_next;
    cnt_t     issue_reg, issue_next;
    logic     dvld_reg, dvld_next;
    cnt_t     didx_reg, didx_next;
    logic     odd_reg, odd_next;

    logic     out_valid_reg, out_valid_next;
    logic     out_bit_reg, out_bit_next;
    cnt_t     out_pos_reg, out_pos_next;
    logic     out_inv_reg, out_inv_next;
    logic     out_ovf_reg, out_ovf_next;
    logic     out_end_reg, out_end_next;

    logic     accept;
    logic     has_room;
    logic     mem_we;
    logic     mem_re;
    logic     mem_rdata;
    logic     out_free;
    logic     out_load;
    logic     last_data;
    logic     flip;
    syn_ctl_t syn_ctl;
    cnt_t     syn;
    logic     syn_invalid;

    // Configuration is always taken; the contract keeps writes to idle periods.
    assign cfg_ready = 1'b1;

    assign code_stall = (state_reg != ST_LOAD);
    assign accept     = code_valid && !code_stall;
    assign has_room   = count_reg < MAX_CNT;
    assign mem_we     = accept && has_room;

    // The output register is free when empty or when its result is transferred now.
    assign out_free  = !out_valid_reg || !result_stall;
    assign out_load  = (state_reg == ST_EMIT) && dvld_reg && out_free;
    assign last_data = (didx_reg == len_reg - cnt_t'(1));

    // The bit at position syn (counted from the last bit) sits at index len - syn.
    assign flip = (syn != '0) && !syn_invalid && (didx_reg == len_reg - syn);

    hcc_bit_mem #(
        .DEPTH (MAX_CODE_BITS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (code_bit),
        .re    (mem_re),
        .raddr (issue_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    hcc_syndrome u_syn (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (syn_ctl),
        .len        (len_reg),
        .odd_parity (odd_reg),
        .syn        (syn),
        .invalid    (syn_invalid)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        len_next       = len_reg;
        issue_next     = issue_reg;
        dvld_next      = dvld_reg;
        didx_next      = didx_reg;
        odd_next       = odd_reg;
        mem_re         = 1'b0;
        syn_ctl        = '0;
        out_bit_next   = out_bit_reg;
        out_pos_next   = out_pos_reg;
        out_inv_next   = out_inv_reg;
        out_ovf_next   = out_ovf_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (cfg_valid)
        begin
            odd_next = cfg_data;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_bit)
                    begin
                        len_next      = has_room ? count_reg + cnt_t'(1) : count_reg;
                        issue_next    = '0;
                        dvld_next     = 1'b0;
                        syn_ctl.clear = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                mem_re          = issue_reg < len_reg;
                syn_ctl.en      = dvld_reg;
                syn_ctl.bit_val = mem_rdata;
                syn_ctl.pos     = len_reg - didx_reg;
                dvld_next       = mem_re;
                didx_next       = issue_reg;
                if (mem_re)
                begin
                    issue_next = issue_reg + cnt_t'(1);
                end
                if (dvld_reg && last_data)
                begin
                    issue_next = '0;
                    dvld_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                mem_re = (issue_reg < len_reg) && (!dvld_reg || out_load);
                if (mem_re)
                begin
                    issue_next = issue_reg + cnt_t'(1);
                    didx_next  = issue_reg;
                    dvld_next  = 1'b1;
                end
                else if (out_load)
                begin
                    dvld_next = 1'b0;
                end
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = mem_rdata ^ flip;
                    out_pos_next   = syn;
                    out_inv_next   = syn_invalid;
                    out_ovf_next   = ovf_reg;
                    out_end_next   = last_data;
                    if (last_data)
                    begin
                        // The last bit of the word now sits in the output register; loading may resume.
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            len_reg       <= '0;
            issue_reg     <= '0;
            dvld_reg      <= 1'b0;
            didx_reg      <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            len_reg       <= len_next;
            issue_reg     <= issue_next;
            dvld_reg      <= dvld_next;
            didx_reg      <= didx_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset; it is qualified by result_valid.
    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
        out_pos_reg <= out_pos_next;
        out_inv_reg <= out_inv_next;
        out_ovf_reg <= out_ovf_next;
        out_end_reg <= out_end_next;
    end

    assign result_valid     = out_valid_reg;
    assign corrected_bit    = out_bit_reg;
    assign error_position   = out_pos_reg;
    assign position_invalid = out_inv_reg;
    assign overflowed       = out_ovf_reg;
    assign run_end          = out_end_reg;

endmodule

/* src/hcc_bit_mem.sv */
module hcc_bit_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/hcc_syndrome.sv */
module hcc_syndrome (
    input  logic             clk,
    input  logic             rst_n,
    input  hcc_pkg::syn_ctl_t ctl,
    input  hcc_pkg::cnt_t    len,
    input  logic             odd_parity,
    output hcc_pkg::cnt_t    syn,
    output logic             invalid
);

    import hcc_pkg::*;

    cnt_t acc_reg;
    cnt_t acc_next;

    // Each stored one contributes its position to every group it belongs to.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.en && ctl.bit_val)
        begin
            acc_next = acc_reg ^ ctl.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Odd parity seeds every group that exists for this length.
    assign syn     = acc_reg ^ (odd_parity ? group_mask(len) : '0);
    assign invalid = syn > len;

endmodule

/* sim/tb_hamming_code_check_correct.sv */
module tb_hamming_code_check_correct;

    import hcc_pkg::cnt_t;

    localparam int CODE_CAPACITY = 64;
    // Cycles allowed after the last result before the block is taken as idle.
    localparam int SETTLE_CYCLES = CODE_CAPACITY + 8;

    // One corrected bit as the block reports it.
    typedef struct packed {
        logic corrected_bit;
        cnt_t error_position;
        logic position_invalid;
        logic overflowed;
        logic run_end;
    } decoded_bit_t;

    // Receiver behaviour. Each pattern is held for a random stretch of cycles.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } stall_pattern_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    logic code_valid = 1'b0;
    logic code_stall;
    logic code_bit = 1'b0;
    logic final_bit = 1'b0;

    logic result_valid;
    logic result_stall = 1'b0;
    logic corrected_bit;
    logic [6:0] error_position;
    logic position_invalid;
    logic overflowed;
    logic run_end;

    // Shadow of the decoder: the bits of the word being loaded, their count,
    // the sticky overflow and the parity setting last written.
    logic [CODE_CAPACITY-1:0] stored_word;
    int stored_count = 0;
    logic store_overflow = 1'b0;
    logic parity_mode = 1'b0;

    // Corrected bits that the decoder still owes, oldest first.
    decoded_bit_t awaited_bits[$];

    // Sender burst state.
    int burst_left = 0;
    bit sender_gaps_on = 1'b1;

    stall_pattern_t stall_mode = STALL_NONE;
    int stall_cycles = 0;

    int bits_sent = 0;
    int words_sent = 0;
    int results_checked = 0;
    int overflow_words = 0;
    int invalid_words = 0;
    int fault_count = 0;

    decoded_bit_t observed_bit;
    decoded_bit_t predicted_bit;

    hamming_code_check_correct #(
        .MAX_CODE_BITS(CODE_CAPACITY)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .code_valid(code_valid),
        .code_stall(code_stall),
        .code_bit(code_bit),
        .final_bit(final_bit),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .corrected_bit(corrected_bit),
        .error_position(error_position),
        .position_invalid(position_invalid),
        .overflowed(overflowed),
        .run_end(run_end)
    );

    always #5 clk = ~clk;

    // Syndrome of a word held in entry order: entry k is at position len - k.
    // Each power-of-two group not beyond the length is checked, seeded with the
    // parity setting, and every failing group adds its index to the syndrome.
    function automatic cnt_t syndrome_of_word(input logic [CODE_CAPACITY-1:0] word,
                                             input int len, input logic odd);
        cnt_t syn;
        logic acc;
        syn = '0;
        for (int grp = 1; grp <= len; grp = grp << 1)
        begin
            acc = odd;
            for (int pos = 1; pos <= len; pos++)
            begin
                if ((pos & grp) != 0)
                    acc = acc ^ word[len - pos];
            end
            if (acc)
                syn = syn + cnt_t'(grp);
        end
        return syn;
    endfunction

    // Update the shadow with one accepted code bit. On the final bit the whole
    // corrected word is queued, one expected transfer per stored bit.
    task automatic absorb_code_bit(input logic bit_val, input logic is_final);
        cnt_t syn;
        logic beyond;
        int len;
        logic [CODE_CAPACITY-1:0] fixed;
        decoded_bit_t entry;
        if (stored_count < CODE_CAPACITY)
        begin
            stored_word[stored_count] = bit_val;
            stored_count++;
        end
        else
        begin
            // Store full: the bit is dropped, the final one included.
            store_overflow = 1'b1;
        end
        if (is_final)
        begin
            len = stored_count;
            syn = syndrome_of_word(stored_word, len, parity_mode);
            beyond = int'(syn) > len;
            fixed = stored_word;
            // A syndrome beyond the word length points at no bit; nothing is flipped.
            if (syn != '0 && !beyond)
                fixed[len - int'(syn)] = ~fixed[len - int'(syn)];
            for (int k = 0; k < len; k++)
            begin
                entry.corrected_bit = fixed[k];
                entry.error_position = syn;
                entry.position_invalid = beyond;
                entry.overflowed = store_overflow;
                entry.run_end = (k == len - 1);
                awaited_bits.push_back(entry);
            end
            if (store_overflow)
                overflow_words++;
            if (beyond)
                invalid_words++;
            stored_count = 0;
            store_overflow = 1'b0;
        end
    endtask

    // Offer one code bit and wait for its transfer. The sender works in bursts;
    // at the start of each burst it may first drop valid for a random gap. Valid is
    // left high on return so that a following bit goes out back to back.
    task automatic send_code_bit(input logic bit_val, input logic is_final);
        int gap;
        if (burst_left == 0)
        begin
            gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                code_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        code_valid <= 1'b1;
        code_bit <= bit_val;
        final_bit <= is_final;
        @(posedge clk);
        while (code_stall)
            @(posedge clk);
        absorb_code_bit(bit_val, is_final);
        bits_sent++;
    endtask

    // Send a code word of total_len bits. Unless scrambled, the stored part is
    // first made a proper code word for the current parity setting by fixing
    // the check bits, and then up to two bit errors are put in (0 means none).
    // Bits beyond the store's capacity are random and will be dropped.
    task automatic send_word(input int total_len, input bit scrambled,
                             input int err_a, input int err_b);
        logic [CODE_CAPACITY-1:0] word;
        cnt_t syn;
        int held;
        held = (total_len < CODE_CAPACITY) ? total_len : CODE_CAPACITY;
        for (int k = 0; k < CODE_CAPACITY; k++)
            word[k] = 1'($urandom_range(0, 1));
        if (!scrambled)
        begin
            // Position g only belongs to group g, so flipping it clears that check.
            syn = syndrome_of_word(word, held, parity_mode);
            for (int g = 1; g <= held; g = g << 1)
            begin
                if ((int'(syn) & g) != 0)
                    word[held - g] = ~word[held - g];
            end
            if (err_a != 0)
                word[held - err_a] = ~word[held - err_a];
            if (err_b != 0)
                word[held - err_b] = ~word[held - err_b];
        end
        for (int k = 0; k < total_len; k++)
            send_code_bit((k < held) ? word[k] : 1'($urandom_range(0, 1)),
                          k == total_len - 1);
        words_sent++;
    endtask

    // Stop sending and wait until every owed result has been transferred,
    // then let the block settle for the given number of cycles.
    task automatic pause_until_drained(input int settle);
        code_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaited_bits.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the parity register while the block is idle.
    task automatic set_parity_mode(input logic odd);
        pause_until_drained(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data <= odd;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        parity_mode = odd;
    endtask

    task automatic report_fault(input string what, input decoded_bit_t want,
                                input decoded_bit_t got);
        fault_count++;
        if (fault_count <= 10)
            $display({"%s: expected bit=%b pos=%0d inv=%b ovf=%b end=%b, ",
                      "got bit=%b pos=%0d inv=%b ovf=%b end=%b"},
                     what, want.corrected_bit, want.error_position, want.position_invalid,
                     want.overflowed, want.run_end, got.corrected_bit, got.error_position,
                     got.position_invalid, got.overflowed, got.run_end);
    endtask

    // Short words under even parity: single-bit words, a two-bit word whose
    // checks both fail so that the syndrome lies beyond its length, and small
    // proper words with and without a bit error at either end.
    task automatic test_short_words();
        set_parity_mode(1'b0);
        send_code_bit(1'b0, 1'b1);
        send_code_bit(1'b1, 1'b1);
        send_code_bit(1'b1, 1'b0);
        send_code_bit(1'b1, 1'b1);
        send_word(3, 1'b0, 0, 0);
        send_word(3, 1'b0, 3, 0);
        send_word(4, 1'b0, 4, 0);
        send_word(7, 1'b0, 1, 0);
    endtask

    // Single-bit words, proper words with and without a bit error, and a scrambled word under odd parity.
    task automatic test_odd_parity();
        set_parity_mode(1'b1);
        send_code_bit(1'b1, 1'b1);
        send_code_bit(1'b0, 1'b1);
        send_word(7, 1'b0, 0, 0);
        send_word(7, 1'b0, 7, 0);
        send_word(5, 1'b1, 0, 0);
    endtask

    // Words that fill the store: an error at the top position, a double error
    // giving the largest syndrome, and a word that runs past capacity and so
    // loses its last bits, the final one included.
    task automatic test_full_store();
        send_word(CODE_CAPACITY, 1'b0, CODE_CAPACITY, 0);
        send_word(CODE_CAPACITY, 1'b0, CODE_CAPACITY - 1, CODE_CAPACITY);
        send_word(CODE_CAPACITY + 6, 1'b0, 1, 0);
    endtask

    // Random words in four phases that alternate the parity setting. Most are
    // proper words with no error or one error; some carry two errors and some
    // are random bits. Most words are short, a few fill or overrun the store.
    // The third phase sends without gaps.
    task automatic test_random_traffic();
        int goal;
        int len;
        int held;
        int pick;
        int err_a;
        int err_b;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_parity_mode(phase[0]);
            sender_gaps_on = (phase != 2);
            goal = bits_sent + 25;
            while (bits_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    len = $urandom_range(1, 15);
                else if (pick < 95)
                    len = $urandom_range(16, 40);
                else
                    len = $urandom_range(41, CODE_CAPACITY + 8);
                held = (len < CODE_CAPACITY) ? len : CODE_CAPACITY;
                pick = $urandom_range(0, 99);
                err_a = (pick >= 40) ? $urandom_range(1, held) : 0;
                err_b = (pick >= 90) ? $urandom_range(1, held) : 0;
                send_word(len, pick < 15, err_a, err_b);
                // Now and then hold the sender until the decoder has caught up.
                if ($urandom_range(0, 9) == 0)
                    pause_until_drained(0);
            end
        end
    endtask

    // The receiver stalls on a pattern that changes every so often, from
    // never stalling to stalling most of the time.
    always @(posedge clk)
    begin
        if (stall_cycles == 0)
        begin
            stall_mode <= stall_pattern_t'($urandom_range(0, 3));
            stall_cycles <= $urandom_range(20, 200);
        end
        else
        begin
            stall_cycles <= stall_cycles - 1;
        end
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  result_stall <= ($urandom_range(0, 1) == 0);
            default:     result_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Every result transfer is compared with the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            observed_bit.corrected_bit = corrected_bit;
            observed_bit.error_position = error_position;
            observed_bit.position_invalid = position_invalid;
            observed_bit.overflowed = overflowed;
            observed_bit.run_end = run_end;
            results_checked++;
            if (awaited_bits.size() == 0)
            begin
                report_fault("unexpected result", 'x, observed_bit);
            end
            else
            begin
                predicted_bit = awaited_bits.pop_front();
                if (observed_bit !== predicted_bit)
                    report_fault("mismatch", predicted_bit, observed_bit);
            end
        end
    end

    initial
    begin
        int spin;
        spin = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_words();
        test_odd_parity();
        test_full_store();
        test_random_traffic();

        // All bits are in; wait for the owed results, then watch for strays.
        code_valid <= 1'b0;
        @(posedge clk);
        while (awaited_bits.size() != 0 && spin < 50000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_bits.size() != 0)
        begin
            fault_count += awaited_bits.size();
            $display("%0d expected results never arrived", awaited_bits.size());
        end

        $display({"Decoded %0d code words from %0d code bits under even and odd parity, ",
                  "%0d results checked."},
                 words_sent, bits_sent, results_checked);
        $display({"Of these, %0d words overran the store and %0d had an error position ",
                  "beyond their length."},
                 overflow_words, invalid_words);
        if (fault_count == 0)
            $display("hamming_code_check_correct regression: pass");
        else
            $display("hamming_code_check_correct regression: fail");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #3000000;
        $display("hamming_code_check_correct regression: fail");
        $finish;
    end

endmodule
